[rtl/igl_pkg.sv]
// Shared types and constants for the integer gcd/lcm block.
`default_nettype none
package igl_pkg;

    localparam int unsigned OPND_W   = 32;
    localparam int unsigned RESULT_W = 31;
    localparam int unsigned PROD_W   = 2 * OPND_W;
    localparam int unsigned CNT_W    = $clog2(OPND_W);

    localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

    localparam logic OP_GCD = 1'b0;
    localparam logic OP_LCM = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ORDER,
        S_TEST,
        S_REM,
        S_GEND,
        S_QUO,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [OPND_W-1:0] dividend;
        logic [OPND_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [OPND_W-1:0] quotient;
        logic [OPND_W-1:0] remainder;
    } t_div_rsp;

    function automatic logic [OPND_W-1:0] magnitude(input logic [OPND_W-1:0] v);
        magnitude = v[OPND_W-1] ? (OPND_W'(0) - v) : v;
    endfunction

endpackage
`default_nettype wire

[rtl/integer_gcd_lcm.sv]
// Top level: gcd / lcm of operand magnitudes on a shared serial divider.
// Sequence: accept, order, then a test and a serial divide per Euclid remainder step
//   (up to about 46 steps), a final test and the gcd end state, then the output state
//   and the result beat. lcm with both magnitudes nonzero adds a divide and a multiply.
// Throughput: one item at a time; busy stays high from accept until the result beat.
// Reset: synchronous active-low; clears sequencer, divider control and o_valid.
// The result beat lasts one cycle on o_valid; the receiver cannot stall it.
`default_nettype none
module integer_gcd_lcm (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output      logic                             busy,
    input  wire logic                             i_operation,
    input  wire logic signed [igl_pkg::OPND_W-1:0] i_operand_a,
    input  wire logic signed [igl_pkg::OPND_W-1:0] i_operand_b,
    output      logic                             o_valid,
    output      logic [igl_pkg::RESULT_W-1:0]     o_result,
    output      logic                             o_overflow
);

    igl_pkg::t_state   r_state, n_state;
    igl_pkg::t_div_req div_req;
    igl_pkg::t_div_rsp div_rsp;

    // operand and working registers
    logic                          r_op, n_op;
    logic [igl_pkg::OPND_W-1:0]    r_ma, n_ma;
    logic [igl_pkg::OPND_W-1:0]    r_mb, n_mb;
    logic [igl_pkg::OPND_W-1:0]    r_lo, n_lo;   // smaller Euclid value
    logic [igl_pkg::OPND_W-1:0]    r_hi, n_hi;   // larger Euclid value; gcd at end
    logic [igl_pkg::OPND_W-1:0]    r_quo, n_quo; // |a| / gcd for lcm
    logic [igl_pkg::PROD_W-1:0]    r_value, n_value;
    logic                          r_valid, n_valid;
    logic [igl_pkg::RESULT_W-1:0]  r_result, n_result;
    logic                          r_ovf, n_ovf;
    logic                          lcm_div;

    igl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // lcm needs the extra divide only when both magnitudes are nonzero
    assign lcm_div = (r_op == igl_pkg::OP_LCM) && (r_ma != '0) && (r_mb != '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            igl_pkg::S_IDLE:  if (start) n_state = igl_pkg::S_ORDER;
            igl_pkg::S_ORDER: n_state = igl_pkg::S_TEST;
            igl_pkg::S_TEST:  n_state = (r_lo != '0) ? igl_pkg::S_REM : igl_pkg::S_GEND;
            igl_pkg::S_REM:   if (div_rsp.done) n_state = igl_pkg::S_TEST;
            igl_pkg::S_GEND:  n_state = lcm_div ? igl_pkg::S_QUO : igl_pkg::S_OUT;
            igl_pkg::S_QUO:   if (div_rsp.done) n_state = igl_pkg::S_MUL;
            igl_pkg::S_MUL:   n_state = igl_pkg::S_OUT;
            igl_pkg::S_OUT:   n_state = igl_pkg::S_IDLE;
            default:          n_state = igl_pkg::S_IDLE;
        endcase
    end

    // datapath controls and next values
    always_comb begin
        n_op     = r_op;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_quo    = r_quo;
        n_value  = r_value;
        n_valid  = 1'b0;
        n_result = r_result;
        n_ovf    = r_ovf;
        div_req.start    = 1'b0;
        div_req.dividend = r_hi;
        div_req.divisor  = r_lo;
        case (r_state)
            igl_pkg::S_IDLE: begin
                if (start) begin
                    n_op = i_operation;
                    n_ma = igl_pkg::magnitude(i_operand_a);
                    n_mb = igl_pkg::magnitude(i_operand_b);
                end
            end
            igl_pkg::S_ORDER: begin
                if (r_ma > r_mb) begin
                    n_lo = r_mb;
                    n_hi = r_ma;
                end else begin
                    n_lo = r_ma;
                    n_hi = r_mb;
                end
            end
            igl_pkg::S_TEST: begin
                div_req.start = (r_lo != '0);
            end
            igl_pkg::S_REM: begin
                if (div_rsp.done) begin
                    n_hi = r_lo;
                    n_lo = div_rsp.remainder;
                end
            end
            igl_pkg::S_GEND: begin
                if (r_op == igl_pkg::OP_GCD) begin
                    n_value = {{(igl_pkg::PROD_W-igl_pkg::OPND_W){1'b0}}, r_hi};
                end else begin
                    n_value = '0;   // zero operand: lcm is zero, no divide
                end
                div_req.start    = lcm_div;
                div_req.dividend = r_ma;
                div_req.divisor  = r_hi;
            end
            igl_pkg::S_QUO: begin
                if (div_rsp.done) n_quo = div_rsp.quotient;
            end
            igl_pkg::S_MUL: begin
                n_value = igl_pkg::PROD_W'(r_quo) * igl_pkg::PROD_W'(r_mb);
            end
            igl_pkg::S_OUT: begin
                n_valid = 1'b1;
                if (r_value > igl_pkg::PROD_W'(igl_pkg::RESULT_MAX)) begin
                    n_result = igl_pkg::RESULT_MAX;
                    n_ovf    = 1'b1;
                end else begin
                    n_result = r_value[igl_pkg::RESULT_W-1:0];
                    n_ovf    = 1'b0;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= igl_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_op     <= n_op;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_quo    <= n_quo;
        r_value  <= n_value;
        r_result <= n_result;
        r_ovf    <= n_ovf;
    end

    assign busy       = (r_state != igl_pkg::S_IDLE);
    assign o_valid    = r_valid;
    assign o_result   = r_result;
    assign o_overflow = r_ovf;

    // checks
    a_out_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == igl_pkg::S_OUT) |=> o_valid)
        else $error("result beat missing after output state");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_result == igl_pkg::RESULT_MAX))
        else $error("overflow without saturated result");

    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (div_req.divisor != '0))
        else $error("divide started with zero divisor");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted beat did not raise busy");

endmodule
`default_nettype wire

[rtl/igl_div.sv]
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module igl_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire igl_pkg::t_div_req i_req,
    output igl_pkg::t_div_rsp      o_rsp
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [igl_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [igl_pkg::OPND_W-1:0]    r_rem, n_rem;
    logic [igl_pkg::OPND_W-1:0]    r_quo, n_quo;
    logic [igl_pkg::OPND_W-1:0]    r_dvs, n_dvs;
    logic [igl_pkg::OPND_W:0]      rem_shift;
    logic [igl_pkg::OPND_W:0]      diff;

    assign rem_shift = {r_rem, r_quo[igl_pkg::OPND_W-1]};
    assign diff      = rem_shift - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // restore step: keep the shifted remainder when it is below the divisor
            if (!diff[igl_pkg::OPND_W]) begin
                n_rem = diff[igl_pkg::OPND_W-1:0];
                n_quo = {r_quo[igl_pkg::OPND_W-2:0], 1'b1};
            end else begin
                n_rem = rem_shift[igl_pkg::OPND_W-1:0];
                n_quo = {r_quo[igl_pkg::OPND_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (&r_cnt) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule
`default_nettype wire
